>>> rtl/ordered_array_table_engine_unit_macros.svh
// Assertion macros for the ordered array table engine.
`ifndef ORDERED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define OATE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("oate assertion failed");
`define OATE_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("oate forbidden condition");
`else
`define OATE_ASSERT(lbl, clk, rst, prop)
`define OATE_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> rtl/oate_pkg.sv
// Shared types and constants for the ordered array table engine.
package oate_pkg;

  localparam int CAPACITY_DEFAULT = 128;
  localparam int VALUE_W = 32;
  localparam int POS_W = 8;
  localparam int REQ_W = 3;
  localparam int FOUND_W = 7;
  localparam int COUNT_W = 8;

  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_INS_START = 3'd1,
    REQ_INS_END   = 3'd2,
    REQ_INS_AT    = 3'd3,
    REQ_DEL_AT    = 3'd4,
    REQ_SEARCH    = 3'd5,
    REQ_REVERSE   = 3'd6,
    REQ_READ      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_INS_WR,
    S_SEARCH,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_REV_D,
    S_READ_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [FOUND_W-1:0]     found_index;
    logic [VALUE_W-1:0]     read_value;
    logic [COUNT_W-1:0]     count;
  } res_t;

endpackage

>>> rtl/oate_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/oate_ctrl.sv
// Sequencer: address walkers src and hi and one comparator drive the entry RAM.
module oate_ctrl #(
  parameter int CAPACITY = oate_pkg::CAPACITY_DEFAULT,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [oate_pkg::REQ_W-1:0]   in_req,
  input  logic [oate_pkg::VALUE_W-1:0] in_value,
  input  logic [oate_pkg::POS_W-1:0]   in_pos,
  output logic                         ready,
  input  logic                         out_free,
  output logic                         res_valid,
  output oate_pkg::res_t               res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [oate_pkg::VALUE_W-1:0] mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [oate_pkg::VALUE_W-1:0] mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > oate_pkg::POS_W) ? CW : oate_pkg::POS_W;

  oate_pkg::state_t  state, state_next;
  oate_pkg::req_t    req;
  oate_pkg::status_t st;
  logic [oate_pkg::VALUE_W-1:0] val;
  logic [oate_pkg::VALUE_W-1:0] tmp;
  logic [oate_pkg::VALUE_W-1:0] rdv;
  logic [oate_pkg::POS_W-1:0]   pos;
  logic [CW-1:0]                count;
  logic [AW-1:0]                src, hi, wa, stop, srcq, found, ins_pos;
  logic                         rem, pend, chk, up;
  logic [PW-1:0]                pos_x, cnt_x;
  logic                         full, match, rev_more;

  assign pos_x = PW'(pos);
  assign cnt_x = PW'(count);
  assign full = cnt_x >= PW'(CAPACITY);
  assign match = chk && (mem_rdata == val);
  assign rev_more = ({1'b0, src} + (AW + 1)'(2)) < {1'b0, hi};

  always_comb begin
    case (req)
      oate_pkg::REQ_INS_START: ins_pos = '0;
      oate_pkg::REQ_INS_END:   ins_pos = count[AW-1:0];
      default:                 ins_pos = pos_x[AW-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oate_pkg::S_IDLE: begin
        if (in_valid) state_next = oate_pkg::S_DECODE;
      end
      oate_pkg::S_DECODE: begin
        state_next = oate_pkg::S_FIN;
        case (req)
          oate_pkg::REQ_INS_START, oate_pkg::REQ_INS_END, oate_pkg::REQ_INS_AT: begin
            if (!(req == oate_pkg::REQ_INS_AT && pos_x > cnt_x) && !full)
              state_next = oate_pkg::S_SHIFT;
          end
          oate_pkg::REQ_DEL_AT: begin
            if (pos_x < cnt_x) state_next = oate_pkg::S_SHIFT;
          end
          oate_pkg::REQ_SEARCH:  state_next = oate_pkg::S_SEARCH;
          oate_pkg::REQ_REVERSE: begin
            if (cnt_x > PW'(1)) state_next = oate_pkg::S_REV_A;
          end
          oate_pkg::REQ_READ: begin
            if (pos_x < cnt_x) state_next = oate_pkg::S_READ_WAIT;
          end
          default: state_next = oate_pkg::S_FIN;
        endcase
      end
      oate_pkg::S_SHIFT: begin
        if (!rem && !pend) state_next = up ? oate_pkg::S_INS_WR : oate_pkg::S_FIN;
      end
      oate_pkg::S_INS_WR: state_next = oate_pkg::S_FIN;
      oate_pkg::S_SEARCH: begin
        if (match || (!rem && !chk)) state_next = oate_pkg::S_FIN;
      end
      oate_pkg::S_REV_A: state_next = oate_pkg::S_REV_B;
      oate_pkg::S_REV_B: state_next = oate_pkg::S_REV_C;
      oate_pkg::S_REV_C: state_next = oate_pkg::S_REV_D;
      oate_pkg::S_REV_D: state_next = rev_more ? oate_pkg::S_REV_A : oate_pkg::S_FIN;
      oate_pkg::S_READ_WAIT: state_next = oate_pkg::S_FIN;
      oate_pkg::S_FIN: begin
        if (out_free) state_next = oate_pkg::S_IDLE;
      end
      default: state_next = oate_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready = 1'b0;
    res_valid = 1'b0;
    mem_we = 1'b0;
    mem_waddr = wa;
    mem_wdata = mem_rdata;
    mem_raddr = src;
    case (state)
      oate_pkg::S_IDLE: ready = 1'b1;
      oate_pkg::S_DECODE: mem_raddr = pos_x[AW-1:0];
      oate_pkg::S_SHIFT: mem_we = pend;
      oate_pkg::S_INS_WR: begin
        mem_we = 1'b1;
        mem_waddr = stop;
        mem_wdata = val;
      end
      oate_pkg::S_REV_B: mem_raddr = hi;
      oate_pkg::S_REV_C: begin
        mem_we = 1'b1;
        mem_waddr = src;
      end
      oate_pkg::S_REV_D: begin
        mem_we = 1'b1;
        mem_waddr = hi;
        mem_wdata = tmp;
      end
      oate_pkg::S_FIN: res_valid = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oate_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        oate_pkg::S_DECODE: begin
          if (req == oate_pkg::REQ_CLEAR) count <= '0;
        end
        oate_pkg::S_SHIFT: begin
          if (!rem && !pend && !up) count <= count - CW'(1);
        end
        oate_pkg::S_INS_WR: count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      oate_pkg::S_IDLE: begin
        req <= oate_pkg::req_t'(in_req);
        val <= in_value;
        pos <= in_pos;
        st <= oate_pkg::STAT_OK;
        found <= '0;
        rdv <= '0;
        pend <= 1'b0;
        chk <= 1'b0;
      end
      oate_pkg::S_DECODE: begin
        case (req)
          oate_pkg::REQ_INS_START, oate_pkg::REQ_INS_END, oate_pkg::REQ_INS_AT: begin
            if (req == oate_pkg::REQ_INS_AT && pos_x > cnt_x) st <= oate_pkg::STAT_BADPOS;
            else if (full) st <= oate_pkg::STAT_FULL;
            up <= 1'b1;
            src <= count[AW-1:0] - AW'(1);
            stop <= ins_pos;
            rem <= cnt_x > PW'(ins_pos);
          end
          oate_pkg::REQ_DEL_AT: begin
            if (pos_x >= cnt_x) st <= oate_pkg::STAT_BADPOS;
            up <= 1'b0;
            src <= pos_x[AW-1:0] + AW'(1);
            stop <= count[AW-1:0] - AW'(1);
            rem <= (pos_x + PW'(1)) < cnt_x;
          end
          oate_pkg::REQ_SEARCH: begin
            src <= '0;
            stop <= count[AW-1:0] - AW'(1);
            rem <= cnt_x != '0;
          end
          oate_pkg::REQ_REVERSE: begin
            src <= '0;
            hi <= count[AW-1:0] - AW'(1);
          end
          oate_pkg::REQ_READ: begin
            if (pos_x >= cnt_x) st <= oate_pkg::STAT_BADPOS;
          end
          default: ;
        endcase
      end
      oate_pkg::S_SHIFT: begin
        pend <= rem;
        if (rem) begin
          wa <= up ? src + AW'(1) : src - AW'(1);
          if (src == stop) rem <= 1'b0;
          else src <= up ? src - AW'(1) : src + AW'(1);
        end
      end
      oate_pkg::S_SEARCH: begin
        chk <= rem;
        srcq <= src;
        if (rem) begin
          if (src == stop) rem <= 1'b0;
          else src <= src + AW'(1);
        end
        if (match) found <= srcq;
        else if (!rem && !chk) st <= oate_pkg::STAT_NOTFOUND;
      end
      oate_pkg::S_REV_B: tmp <= mem_rdata;
      oate_pkg::S_REV_D: begin
        src <= src + AW'(1);
        hi <= hi - AW'(1);
      end
      oate_pkg::S_READ_WAIT: rdv <= mem_rdata;
      default: ;
    endcase
  end

  assign res.status = st;
  assign res.found_index = oate_pkg::FOUND_W'(found);
  assign res.read_value = rdv;
  assign res.count = oate_pkg::COUNT_W'(count);

endmodule

>>> rtl/ordered_array_table_engine_unit.sv
// Top level of the ordered array table engine: stream ports, result register, entry RAM.
//
// channel  dir  tdata (low bit up)                           tuser
// s_*      in   value[31:0], position[39:32]                 req_type[2:0]
// m_*      out  found_index[6:0], read_value[38:7], count[46:39]  status[1:0]
//
// One request at a time; the next s_* transfer is taken only once the result is in m_*.
// Clear and refused requests go from decode to the result; read waits for the RAM data.
// Insert at p (start p = 0, end p = count) moves p..count-1 up and writes the value;
// delete moves later ones down; search stops at the first hit; reverse swaps ends inward.
// rst (synchronous) empties the array; RAM contents are not cleared.
// A result waiting in m_* holds back only the next result, not the next request.
`include "ordered_array_table_engine_unit_macros.svh"

module ordered_array_table_engine_unit #(
  parameter int CAPACITY = oate_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // value, position
  input  logic [2:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // found_index, read_value, count
  output logic [1:0]  m_tuser   // status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                         out_free, res_valid;
  oate_pkg::res_t               res;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [oate_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;

  assign out_free = !m_tvalid || m_tready;

  oate_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_req    (s_tuser),
    .in_value  (s_tdata[31:0]),
    .in_pos    (s_tdata[39:32]),
    .ready     (s_tready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  oate_ram #(.WIDTH(oate_pkg::VALUE_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {1'b0, res.count, res.read_value, res.found_index};
    end
  end

  `OATE_ASSERT(a_res_into_free, clk, rst, res_valid |-> (!m_tvalid || m_tready))
  `OATE_ASSERT_NEVER(a_accept_vs_result, clk, rst, (s_tvalid && s_tready) && res_valid)
  `OATE_ASSERT(a_full_count, clk, rst, (res_valid && res.status == oate_pkg::STAT_FULL) |-> (res.count == oate_pkg::COUNT_W'(CAPACITY)))

endmodule
